// File: src/masked_layer_compositor_assert.svh
// Assertion macros for the masked layer compositor.
`ifndef MASKED_LAYER_COMPOSITOR_ASSERT_SVH
`define MASKED_LAYER_COMPOSITOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mlc assertion failed");

// Next-cycle implication, disabled in reset.
`define MLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mlc assertion failed");

`endif

// File: src/mlc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the masked layer compositor.
package mlc_pkg;

    localparam int CHAN_W            = 8;
    localparam int NUM_CHAN          = 4;
    localparam int MASK_W            = 4;
    localparam int OPACITY_W         = 9;
    localparam int OPACITY_FRAC_BITS = 8;

    // saturated opacity, 0..one
    localparam int OPA_Q_W   = OPACITY_FRAC_BITS + 1;
    localparam int OPA_CMP_W = (OPA_Q_W > OPACITY_W) ? OPA_Q_W : OPACITY_W;
    localparam logic [OPA_CMP_W-1:0] OPA_ONE_CMP = OPA_CMP_W'(1) << OPACITY_FRAC_BITS;
    localparam logic [OPA_Q_W-1:0]   OPA_ONE     = OPA_Q_W'(1) << OPACITY_FRAC_BITS;

    // lerp accumulator: cur*(one-a) + v*a + one/2
    localparam int LERP_W = CHAN_W + OPACITY_FRAC_BITS + 2;

    localparam logic [MASK_W-1:0] NONE_RESOLVED = '0;
    localparam logic [CHAN_W-1:0] ALPHA_RESET   = 8'd255;

    // queue depth, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_chan_vec;

    localparam t_chan_vec RUNNING_RESET = {ALPHA_RESET, CHAN_W'(0), CHAN_W'(0), CHAN_W'(0)};

    // classified layer beat; mask already cleared for skipped layers
    typedef struct packed {
        t_chan_vec          chan;
        logic [MASK_W-1:0]  mask;
        logic [OPA_Q_W-1:0] opa;
        logic               last;
    } t_q_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_status;

    typedef struct packed {
        logic [MASK_W-1:0] resolved;
        logic              pop;
        logic              pop_last;
    } t_back_status;

endpackage

// File: src/mlc_layer_if.sv
`timescale 1ns / 1ps
// Layer sample channel: valid/ready plus one layer's beat.
interface mlc_layer_if
    import mlc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAN_W-1:0]    layer_red;
    logic [CHAN_W-1:0]    layer_green;
    logic [CHAN_W-1:0]    layer_blue;
    logic [CHAN_W-1:0]    layer_alpha;
    logic [MASK_W-1:0]    written_mask;
    logic                 layer_visible;
    logic [OPACITY_W-1:0] layer_opacity;
    logic                 last_layer;

    modport source (
        output valid, layer_red, layer_green, layer_blue, layer_alpha,
               written_mask, layer_visible, layer_opacity, last_layer,
        input  ready
    );
    modport sink (
        input  valid, layer_red, layer_green, layer_blue, layer_alpha,
               written_mask, layer_visible, layer_opacity, last_layer,
        output ready
    );
endinterface

// File: src/mlc_pixel_if.sv
`timescale 1ns / 1ps
// Pixel result channel: valid/ready plus the composited RGBA beat.
interface mlc_pixel_if
    import mlc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic [CHAN_W-1:0] pixel_alpha;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
        output ready
    );
endinterface

// File: src/mlc_front.sv
`timescale 1ns / 1ps
// Front end: takes layer beats, saturates opacity and drops skipped layers' masks.
module mlc_front
    import mlc_pkg::*;
(
    mlc_layer_if.sink i_layer,
    input  logic      i_q_full,
    output logic      o_push,
    output t_q_item   o_item
);
    logic [OPA_CMP_W-1:0] opa_ext;
    logic [OPA_CMP_W-1:0] opa_sat;
    logic                 active;

    assign opa_ext = OPA_CMP_W'(i_layer.layer_opacity);
    assign opa_sat = (opa_ext > OPA_ONE_CMP) ? OPA_ONE_CMP : opa_ext;
    assign active  = i_layer.layer_visible && (opa_sat != '0);

    assign i_layer.ready = !i_q_full;
    assign o_push        = i_layer.valid && !i_q_full;

    always_comb begin
        o_item.chan = {i_layer.layer_alpha, i_layer.layer_blue,
                       i_layer.layer_green, i_layer.layer_red};
        o_item.mask = active ? i_layer.written_mask : NONE_RESOLVED;
        o_item.opa  = opa_sat[OPA_Q_W-1:0];
        o_item.last = i_layer.last_layer;
    end
endmodule

// File: src/mlc_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified beats between front and back.
module mlc_queue
    import mlc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_item   i_item,
    input  logic      i_pop,
    output t_q_item   o_item,
    output t_q_status o_status
);
    t_q_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
endmodule

// File: src/mlc_back.sv
`timescale 1ns / 1ps
// Back end: per-channel lerp into the running pixel and the output register.
module mlc_back
    import mlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_q_item      i_item,
    input  t_q_status    i_q_status,
    output logic         o_pop,
    output t_back_status o_status,
    mlc_pixel_if.source  o_pixel
);
    localparam logic [LERP_W-1:0] LERP_HALF = LERP_W'(1) << (OPACITY_FRAC_BITS - 1);

    logic [MASK_W-1:0] r_resolved;
    logic [MASK_W-1:0] n_resolved;
    t_chan_vec         r_running;
    t_chan_vec         n_running;
    t_chan_vec         lerp_val;
    t_chan_vec         r_out;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [MASK_W-1:0] consider;
    logic              out_free;

    function automatic logic [CHAN_W-1:0] lerp(
        input logic [CHAN_W-1:0]  cur,
        input logic [CHAN_W-1:0]  v,
        input logic [OPA_Q_W-1:0] a
    );
        logic [LERP_W-1:0] sum;
        sum = LERP_W'(cur) * LERP_W'(OPA_ONE - a) + LERP_W'(v) * LERP_W'(a) + LERP_HALF;
        return sum[OPACITY_FRAC_BITS +: CHAN_W];
    endfunction

    assign consider = i_item.mask & ~r_resolved;
    assign out_free = !r_out_valid || o_pixel.ready;
    assign o_pop    = !i_q_status.empty && (!i_item.last || out_free);

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            lerp_val[c] = consider[c] ? lerp(r_running[c], i_item.chan[c], i_item.opa)
                                      : r_running[c];
        end
    end

    always_comb begin
        n_running   = r_running;
        n_resolved  = r_resolved;
        n_out_valid = r_out_valid && !o_pixel.ready;
        if (o_pop) begin
            if (i_item.last) begin
                n_running   = RUNNING_RESET;
                n_resolved  = NONE_RESOLVED;
                n_out_valid = 1'b1;
            end else begin
                n_running  = lerp_val;
                n_resolved = r_resolved | consider;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= RUNNING_RESET;
            r_resolved  <= NONE_RESOLVED;
            r_out_valid <= 1'b0;
        end else begin
            r_running   <= n_running;
            r_resolved  <= n_resolved;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out <= lerp_val;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_red   = r_out[0];
    assign o_pixel.pixel_green = r_out[1];
    assign o_pixel.pixel_blue  = r_out[2];
    assign o_pixel.pixel_alpha = r_out[3];

    assign o_status.resolved = r_resolved;
    assign o_status.pop      = o_pop;
    assign o_status.pop_last = o_pop && i_item.last;
endmodule

// File: src/masked_layer_compositor.sv
// Masked layer compositor top level: front classifier, beat queue, lerp back end.
// A last-layer beat reaches o_pixel through the queue and then the output register.
// Throughput: 1 layer beat per cycle while no last-layer beat waits; the lerp is combinational.
// A pixel beat waiting on o_pixel stalls only the pop of a last-layer beat; beats behind it wait too.
// Reset (i_rst_n low, synchronous): queue emptied, running pixel black with alpha 255,
// no channel resolved, no pixel pending.
`timescale 1ns / 1ps
`include "masked_layer_compositor_assert.svh"
module masked_layer_compositor
    import mlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlc_layer_if.sink   i_layer,
    mlc_pixel_if.source o_pixel
);
    logic         push;
    t_q_item      front_item;
    t_q_item      q_item;
    t_q_status    q_status;
    logic         pop;
    t_back_status back_status;

    mlc_front u_front (
        .i_layer  (i_layer),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_item   (front_item)
    );

    mlc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    mlc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (q_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_status   (back_status),
        .o_pixel    (o_pixel)
    );

    `MLC_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, push, !q_status.full)
    `MLC_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, back_status.pop, !q_status.empty)
    `MLC_ASSERT_IMP(a_last_has_slot, i_clk, i_rst_n, back_status.pop_last,
                    !o_pixel.valid || o_pixel.ready)
    `MLC_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, back_status.pop_last,
                    back_status.resolved == NONE_RESOLVED && o_pixel.valid)
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the masked layer compositor: directed layer table, then random stacks vs a lerp predictor.
module testbench;
    import mlc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 90;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RANDOM_ITEMS   = 400;
    localparam int unsigned FULL_OPACITY   = 1 << OPACITY_FRAC_BITS;

    localparam logic [MASK_W-1:0] MASK_NONE  = 4'b0000;
    localparam logic [MASK_W-1:0] MASK_RED   = 4'b0001;
    localparam logic [MASK_W-1:0] MASK_GREEN = 4'b0010;
    localparam logic [MASK_W-1:0] MASK_BLUE  = 4'b0100;
    localparam logic [MASK_W-1:0] MASK_ALPHA = 4'b1000;
    localparam logic [MASK_W-1:0] MASK_ALL   = 4'b1111;

    typedef struct packed {
        t_chan_vec            sample;
        logic [MASK_W-1:0]    mask;
        logic                 visible;
        logic [OPACITY_W-1:0] opacity;
        logic                 last;
    } t_layer_beat;

    typedef struct {
        t_layer_beat beat;
        bit          pinned;
        t_chan_vec   pixel;
    } t_directed_row;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mlc_layer_if layer_bus ();
    mlc_pixel_if pixel_bus ();

    masked_layer_compositor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_layer (layer_bus),
        .o_pixel (pixel_bus)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    t_chan_vec         acc_chan     = RUNNING_RESET;
    logic [MASK_W-1:0] acc_resolved = NONE_RESOLVED;
    t_chan_vec         pending_pixels[$];

    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        drv_pinned  = 1'b0;
    t_chan_vec drv_pinned_px;
    int        burst_left  = 0;
    bit        gaps_on     = 1'b1;
    bit        hold_request = 1'b0;
    int        hold_left   = 0;
    int        rx_phase_left = 0;
    t_rx_mode  rx_mode     = RX_OPEN;

    t_directed_row directed_rows[$];

    string chan_name[NUM_CHAN] = '{"red", "green", "blue", "alpha"};

    function automatic t_chan_vec rgba(input logic [7:0] r, g, b, a);
        return {a, b, g, r};
    endfunction

    function automatic t_layer_beat layer_beat(input logic [7:0] r, g, b, a,
                                               input logic [MASK_W-1:0] mask,
                                               input logic vis,
                                               input int unsigned opa,
                                               input logic last);
        t_layer_beat beat;
        beat.sample  = rgba(r, g, b, a);
        beat.mask    = mask;
        beat.visible = vis;
        beat.opacity = OPACITY_W'(opa);
        beat.last    = last;
        return beat;
    endfunction

    function automatic void add_row(input t_layer_beat beat, input bit pinned,
                                    input t_chan_vec px);
        t_directed_row row;
        row.beat   = beat;
        row.pinned = pinned;
        row.pixel  = px;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Folds one layer into the running pixel; returns 1 when the pixel is emitted.
    function automatic bit composite_layer(input t_layer_beat beat, output t_chan_vec px);
        int unsigned       opa;
        logic [MASK_W-1:0] take;
        opa = (beat.opacity > FULL_OPACITY) ? FULL_OPACITY : beat.opacity;
        if (beat.visible && opa != 0) begin
            take = beat.mask & ~acc_resolved;
            for (int c = 0; c < NUM_CHAN; c++) begin
                if (take[c]) begin
                    acc_chan[c] = CHAN_W'((acc_chan[c] * (FULL_OPACITY - opa)
                                  + beat.sample[c] * opa + FULL_OPACITY / 2)
                                  >> OPACITY_FRAC_BITS);
                end
            end
            acc_resolved = acc_resolved | take;
        end
        px = acc_chan;
        if (beat.last) begin
            acc_chan     = RUNNING_RESET;
            acc_resolved = NONE_RESOLVED;
        end
        return beat.last;
    endfunction

    // both channels sampled at the rising edge
    always @(posedge i_clk) begin
        t_layer_beat beat;
        t_chan_vec   px;
        t_chan_vec   got;
        bit          busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (layer_bus.valid && layer_bus.ready) begin
                busy = 1'b1;
                beat.sample  = rgba(layer_bus.layer_red, layer_bus.layer_green,
                                    layer_bus.layer_blue, layer_bus.layer_alpha);
                beat.mask    = layer_bus.written_mask;
                beat.visible = layer_bus.layer_visible;
                beat.opacity = layer_bus.layer_opacity;
                beat.last    = layer_bus.last_layer;
                if (composite_layer(beat, px))
                    pending_pixels.insert(pending_pixels.size(),
                                          drv_pinned ? drv_pinned_px : px);
            end
            if (pixel_bus.valid && pixel_bus.ready) begin
                busy = 1'b1;
                got = rgba(pixel_bus.pixel_red, pixel_bus.pixel_green,
                           pixel_bus.pixel_blue, pixel_bus.pixel_alpha);
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    $display("[%0t] unexpected pixel beat: expected none, got %h",
                             $time, got);
                end else begin
                    px = pending_pixels.pop_front();
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        if (got[c] !== px[c]) begin
                            mismatches++;
                            $display("[%0t] pixel %s: expected %0d, got %0d",
                                     $time, chan_name[c], px[c], got[c]);
                        end
                    end
                end
            end
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("[%0t] timeout: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // pixel sink: phases of differing back-pressure, plus one long hold-off on request
    initial begin
        pixel_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pixel_bus.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                pixel_bus.ready <= 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode       = t_rx_mode'($urandom_range(0, 2));
                    rx_phase_left = $urandom_range(20, 80);
                end
                rx_phase_left--;
                case (rx_mode)
                    RX_OPEN:  pixel_bus.ready <= 1'b1;
                    RX_COIN:  pixel_bus.ready <= 1'($urandom_range(0, 1));
                    default:  pixel_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_layer(input t_layer_beat beat, input bit pinned,
                              input t_chan_vec pinned_px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                layer_bus.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        layer_bus.valid         <= 1'b1;
        layer_bus.layer_red     <= beat.sample[0];
        layer_bus.layer_green   <= beat.sample[1];
        layer_bus.layer_blue    <= beat.sample[2];
        layer_bus.layer_alpha   <= beat.sample[3];
        layer_bus.written_mask  <= beat.mask;
        layer_bus.layer_visible <= beat.visible;
        layer_bus.layer_opacity <= beat.opacity;
        layer_bus.last_layer    <= beat.last;
        drv_pinned    = pinned;
        drv_pinned_px = pinned_px;
        do @(posedge i_clk); while (!layer_bus.ready);
    endtask

    initial begin
        t_layer_beat beat;
        int          counted;
        int          stack_no;
        int          stack_len;
        int          calm_stacks;
        int          pick;
        bit          broken;

        i_rst_n                 = 1'b0;
        layer_bus.valid         = 1'b0;
        layer_bus.layer_red     = '0;
        layer_bus.layer_green   = '0;
        layer_bus.layer_blue    = '0;
        layer_bus.layer_alpha   = '0;
        layer_bus.written_mask  = '0;
        layer_bus.layer_visible = 1'b0;
        layer_bus.layer_opacity = '0;
        layer_bus.last_layer    = 1'b0;
        drv_pinned_px           = RUNNING_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // invisible, saturated, zero and minimum opacity
        add_row(layer_beat(9, 9, 9, 9, MASK_ALL, 0, 256, 1), 1'b1, rgba(0, 0, 0, 255));
        add_row(layer_beat(10, 20, 30, 40, MASK_ALL, 1, 256, 1), 1'b1, rgba(10, 20, 30, 40));
        add_row(layer_beat(255, 255, 255, 255, MASK_ALL, 1, 511, 1), 1'b1,
                rgba(255, 255, 255, 255));
        add_row(layer_beat(0, 0, 0, 0, MASK_ALL, 1, 257, 1), 1'b1, rgba(0, 0, 0, 0));
        add_row(layer_beat(77, 77, 77, 77, MASK_ALL, 1, 0, 1), 1'b1, rgba(0, 0, 0, 255));
        add_row(layer_beat(255, 255, 255, 0, MASK_ALL, 1, 1, 1), 1'b1, rgba(1, 1, 1, 254));
        // first authoring layer wins per channel
        add_row(layer_beat(200, 0, 0, 0, MASK_RED, 1, 256, 0), 1'b0, '0);
        add_row(layer_beat(50, 60, 0, 0, MASK_RED | MASK_GREEN, 1, 256, 0), 1'b0, '0);
        add_row(layer_beat(1, 2, 3, 4, MASK_ALL, 1, 256, 1), 1'b1, rgba(200, 60, 3, 4));
        // fully resolved, lower layer ignored
        add_row(layer_beat(7, 8, 9, 10, MASK_ALL, 1, 256, 0), 1'b0, '0);
        add_row(layer_beat(99, 99, 99, 99, MASK_ALL, 1, 256, 1), 1'b1, rgba(7, 8, 9, 10));
        add_row(layer_beat(123, 45, 67, 89, MASK_NONE, 1, 256, 1), 1'b1, rgba(0, 0, 0, 255));
        // partial blends
        add_row(layer_beat(200, 100, 50, 25, MASK_BLUE | MASK_ALPHA, 1, 128, 0), 1'b0, '0);
        add_row(layer_beat(0, 255, 0, 255, MASK_BLUE | MASK_ALPHA, 1, 255, 0), 1'b0, '0);
        add_row(layer_beat(200, 100, 50, 25, MASK_ALL, 1, 128, 0), 1'b0, '0);
        add_row(layer_beat(5, 5, 5, 5, MASK_ALL, 0, 256, 1), 1'b0, '0);
        add_row(layer_beat(255, 255, 255, 255, MASK_GREEN, 1, 255, 0), 1'b0, '0);
        add_row(layer_beat(0, 0, 0, 0, MASK_ALPHA, 1, 255, 1), 1'b0, '0);
        add_row(layer_beat(8'hAA, 8'h55, 8'hAA, 8'h55, MASK_ALL, 1, 256, 1), 1'b1,
                rgba(8'hAA, 8'h55, 8'hAA, 8'h55));
        add_row(layer_beat(8'h55, 8'hAA, 8'h55, 8'hAA, MASK_ALL, 1, 256, 1), 1'b1,
                rgba(8'h55, 8'hAA, 8'h55, 8'hAA));
        add_row(layer_beat(255, 0, 255, 0, MASK_RED | MASK_BLUE, 1, 300, 0), 1'b0, '0);
        add_row(layer_beat(0, 255, 0, 255, MASK_ALL, 1, 256, 1), 1'b1,
                rgba(255, 255, 255, 255));

        foreach (directed_rows[i])
            send_layer(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].pixel);

        counted     = 0;
        stack_no    = 0;
        calm_stacks = 0;
        while (counted < RANDOM_ITEMS) begin
            stack_len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
                                                    : $urandom_range(1, 4);
            broken = ($urandom_range(0, 9) == 0);
            if (stack_no == 25) begin
                hold_request = 1'b1;
                calm_stacks  = 15;
            end
            if (calm_stacks > 0) begin
                calm_stacks--;
                gaps_on = 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 9) >= 3);
            end
            for (int i = 0; i < stack_len; i++) begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    pick = $urandom_range(0, 9);
                    beat.sample[c] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255
                                   : CHAN_W'($urandom_range(0, 255));
                end
                beat.mask = MASK_W'($urandom_range(0, 15));
                case ($urandom_range(0, 7))
                    0:       beat.opacity = '0;
                    1:       beat.opacity = OPACITY_W'(FULL_OPACITY);
                    2:       beat.opacity = OPACITY_W'($urandom_range(257, 511));
                    3:       beat.opacity = OPACITY_W'($urandom_range(1, 8));
                    default: beat.opacity = OPACITY_W'($urandom_range(1, 255));
                endcase
                if (broken) begin
                    beat.visible = 1'($urandom_range(0, 1));
                    beat.last    = 1'($urandom_range(0, 1));
                end else begin
                    beat.visible = ($urandom_range(0, 9) != 0);
                    beat.last    = (i == stack_len - 1);
                end
                counted++;
                send_layer(beat, 1'b0, '0);
            end
            stack_no++;
        end
        // closes any stack left open by a broken sequence
        send_layer(layer_beat(0, 0, 0, 0, MASK_NONE, 0, 0, 1), 1'b0, '0);

        @(negedge i_clk);
        layer_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/mlc_pkg.sv
src/mlc_layer_if.sv
src/mlc_pixel_if.sv
src/mlc_front.sv
src/mlc_queue.sv
src/mlc_back.sv
src/masked_layer_compositor.sv
tb/testbench.sv
